// ===== hw/rtl/tct_pkg.sv =====
// Shared types and constants of the touch contact tracker.
// Used by the divider, datapath, controller and top level. No dependencies.
package tct_pkg;

   localparam int MAX_CONTACTS = 5;
   localparam int POS_LIMIT    = 4096;

   localparam int SLOT_W      = $clog2(MAX_CONTACTS);
   localparam int CNT_W       = $clog2(MAX_CONTACTS + 1);
   localparam int ID_W        = 8;
   localparam int RAW_W       = 16;
   localparam int WID_W       = 16;
   localparam int STAMP_W     = 16;
   localparam int SCALE_SHIFT = $clog2(POS_LIMIT);
   localparam int POS_W       = SCALE_SHIFT + 1;
   localparam int DIV_W       = RAW_W + SCALE_SHIFT;
   localparam int STEP_W      = $clog2(POS_W);
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [POS_W-1:0] LMAX_POS = POS_W'(POS_LIMIT);

   localparam logic [1:0] ACT_DOWN = 2'd0;
   localparam logic [1:0] ACT_MOVE = 2'd1;
   localparam logic [1:0] ACT_UP   = 2'd2;

   localparam logic [1:0] ERR_OK      = 2'd0;
   localparam logic [1:0] ERR_FULL    = 2'd1;
   localparam logic [1:0] ERR_UNKNOWN = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_AXES = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SCALE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SCALE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLIP_Y    = 3'd4;

   typedef struct packed {
      logic       load_req;
      logic       start_div;
      logic       write_slot;
      logic       remove;
      logic       set_err;
      logic [1:0] err_code;
      logic       emit;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       found;
      logic       full;
      logic       div_done;
      logic       out_free;
      logic       emit_last;
   } dp_stat_type;

endpackage

// ===== hw/rtl/tct_divider.sv =====
// Bit-serial coordinate scaler: raw * POS_LIMIT / full_scale, saturated, optionally mirrored.
// Depends on tct_pkg.
module tct_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [tct_pkg::RAW_W-1:0]  numer,
   input  logic [tct_pkg::RAW_W-1:0]  denom,
   input  logic                       flip,
   output logic                       done,
   output logic [tct_pkg::POS_W-1:0]  result
);

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [tct_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [tct_pkg::DIV_W-1:0]   rem_ff, rem_in;
   logic [tct_pkg::DIV_W-1:0]   den_ff, den_in;
   logic [tct_pkg::POS_W-1:0]   quo_ff, quo_in;
   logic                        sat_ff, sat_in;
   logic                        flip_ff, flip_in;

   logic [tct_pkg::RAW_W-1:0]   fs;
   logic [tct_pkg::DIV_W:0]     num_ext;
   logic [tct_pkg::DIV_W:0]     lim_ext;
   logic [tct_pkg::POS_W-1:0]   sel;

   always_comb begin
      fs      = (denom == '0) ? tct_pkg::RAW_W'(1) : denom;
      num_ext = {1'b0, numer, {tct_pkg::SCALE_SHIFT{1'b0}}};
      lim_ext = {1'b0, fs, {tct_pkg::SCALE_SHIFT{1'b0}}} + (tct_pkg::DIV_W + 1)'(fs);

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      flip_in = flip_ff;

      if (start) begin
         busy_in = 1'b1;
         step_in = tct_pkg::STEP_W'(tct_pkg::POS_W - 1);
         rem_in  = num_ext[tct_pkg::DIV_W-1:0];
         den_in  = {fs, {tct_pkg::SCALE_SHIFT{1'b0}}};
         quo_in  = '0;
         sat_in  = (num_ext >= lim_ext);
         flip_in = flip;
      end else if (busy_ff) begin
         if (rem_ff >= den_ff) begin
            rem_in = rem_ff - den_ff;
            quo_in = {quo_ff[tct_pkg::POS_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[tct_pkg::POS_W-2:0], 1'b0};
         end
         den_in = den_ff >> 1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - tct_pkg::STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      sat_ff  <= sat_in;
      flip_ff <= flip_in;
   end

   always_comb begin
      sel    = sat_ff ? tct_pkg::LMAX_POS : quo_ff;
      result = flip_ff ? (tct_pkg::LMAX_POS - sel) : sel;
   end

   assign done = done_ff;

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");

   a_last_step_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && step_ff == '0) |=> done_ff)
      else $error("divider final step did not raise done");

endmodule

// ===== hw/rtl/tct_datapath.sv =====
// Datapath: request and configuration registers, compacted slot table, scalers and
// result register. Depends on tct_pkg and tct_divider.
module tct_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  tct_pkg::dp_cmd_type            cmd,
   output tct_pkg::dp_stat_type           stat,
   input  logic [1:0]                     req_action,
   input  logic [tct_pkg::ID_W-1:0]       req_track_id,
   input  logic [tct_pkg::RAW_W-1:0]      req_raw_x,
   input  logic [tct_pkg::RAW_W-1:0]      req_raw_y,
   input  logic [tct_pkg::WID_W-1:0]      req_contact_width,
   input  logic [tct_pkg::STAMP_W-1:0]    req_scan_stamp,
   input  logic                           csr_we,
   input  logic [tct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tct_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_has_contact,
   output logic [2:0]                     rsp_slot,
   output logic                           rsp_tip,
   output logic [tct_pkg::ID_W-1:0]       rsp_contact_id,
   output logic [tct_pkg::POS_W-1:0]      rsp_pos_x,
   output logic [tct_pkg::POS_W-1:0]      rsp_pos_y,
   output logic [tct_pkg::WID_W-1:0]      rsp_width_out,
   output logic [tct_pkg::STAMP_W-1:0]    rsp_report_stamp,
   output logic [2:0]                     rsp_active_count,
   output logic                           rsp_last,
   output logic [1:0]                     rsp_error
);

   localparam int N = tct_pkg::MAX_CONTACTS;

   logic                         swap_ff;
   logic [tct_pkg::RAW_W-1:0]    xfs_ff;
   logic [tct_pkg::RAW_W-1:0]    yfs_ff;
   logic                         flipx_ff;
   logic                         flipy_ff;

   logic [1:0]                   act_ff;
   logic [tct_pkg::ID_W-1:0]     id_ff;
   logic [tct_pkg::RAW_W-1:0]    rx_ff;
   logic [tct_pkg::RAW_W-1:0]    ry_ff;
   logic [tct_pkg::WID_W-1:0]    wid_ff;
   logic [tct_pkg::STAMP_W-1:0]  stamp_ff;

   logic [tct_pkg::ID_W-1:0]     ids_ff [N];
   logic                         tips_ff [N];
   logic [tct_pkg::POS_W-1:0]    xs_ff [N];
   logic [tct_pkg::POS_W-1:0]    ys_ff [N];
   logic [tct_pkg::WID_W-1:0]    ws_ff [N];

   logic [tct_pkg::CNT_W-1:0]    cnt_ff;
   logic [tct_pkg::SLOT_W-1:0]   idx_ff;
   logic [1:0]                   err_ff;

   logic                         out_valid_ff;
   logic                         out_has_ff;
   logic [2:0]                   out_slot_ff;
   logic                         out_tip_ff;
   logic [tct_pkg::ID_W-1:0]     out_id_ff;
   logic [tct_pkg::POS_W-1:0]    out_x_ff;
   logic [tct_pkg::POS_W-1:0]    out_y_ff;
   logic [tct_pkg::WID_W-1:0]    out_w_ff;
   logic [tct_pkg::STAMP_W-1:0]  out_stamp_ff;
   logic [2:0]                   out_cnt_ff;
   logic                         out_last_ff;
   logic [1:0]                   out_err_ff;

   logic                         found;
   logic [tct_pkg::SLOT_W-1:0]   pos;
   logic [tct_pkg::SLOT_W-1:0]   target;
   logic                         emit_last;
   logic [tct_pkg::RAW_W-1:0]    ax;
   logic [tct_pkg::RAW_W-1:0]    ay;
   logic                         dx_done;
   logic                         dy_done;
   logic [tct_pkg::POS_W-1:0]    dx_result;
   logic [tct_pkg::POS_W-1:0]    dy_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff  <= 1'b0;
         xfs_ff   <= tct_pkg::RAW_W'(tct_pkg::POS_LIMIT);
         yfs_ff   <= tct_pkg::RAW_W'(tct_pkg::POS_LIMIT);
         flipx_ff <= 1'b0;
         flipy_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            tct_pkg::CSR_SWAP_AXES: swap_ff  <= csr_wdata[0];
            tct_pkg::CSR_X_SCALE:   xfs_ff   <= csr_wdata;
            tct_pkg::CSR_Y_SCALE:   yfs_ff   <= csr_wdata;
            tct_pkg::CSR_FLIP_X:    flipx_ff <= csr_wdata[0];
            tct_pkg::CSR_FLIP_Y:    flipy_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         act_ff   <= req_action;
         id_ff    <= req_track_id;
         rx_ff    <= req_raw_x;
         ry_ff    <= req_raw_y;
         wid_ff   <= req_contact_width;
         stamp_ff <= req_scan_stamp;
      end
   end

   // The lowest active slot holding the id wins.
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if ((tct_pkg::CNT_W'(i) < cnt_ff) && (ids_ff[i] == id_ff)) begin
            found = 1'b1;
            pos   = tct_pkg::SLOT_W'(i);
         end
      end
   end

   always_comb begin
      ax        = swap_ff ? ry_ff : rx_ff;
      ay        = swap_ff ? rx_ff : ry_ff;
      target    = (act_ff == tct_pkg::ACT_DOWN) ? cnt_ff[tct_pkg::SLOT_W-1:0] : pos;
      emit_last = (cnt_ff == '0) ||
                  ((tct_pkg::CNT_W'(idx_ff) + tct_pkg::CNT_W'(1)) >= cnt_ff);
   end

   tct_divider u_div_x (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_div),
      .numer  (ax),
      .denom  (xfs_ff),
      .flip   (flipx_ff),
      .done   (dx_done),
      .result (dx_result)
   );

   tct_divider u_div_y (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_div),
      .numer  (ay),
      .denom  (yfs_ff),
      .flip   (flipy_ff),
      .done   (dy_done),
      .result (dy_result)
   );

   always_ff @(posedge clock) begin
      if (cmd.write_slot) begin
         ids_ff[target]  <= id_ff;
         tips_ff[target] <= (act_ff == tct_pkg::ACT_MOVE);
         xs_ff[target]   <= dx_result;
         ys_ff[target]   <= dy_result;
         ws_ff[target]   <= wid_ff;
      end else if (cmd.remove) begin
         for (int i = 0; i < N - 1; i++) begin
            if (tct_pkg::SLOT_W'(i) >= pos) begin
               ids_ff[i]  <= ids_ff[i+1];
               tips_ff[i] <= tips_ff[i+1];
               xs_ff[i]   <= xs_ff[i+1];
               ys_ff[i]   <= ys_ff[i+1];
               ws_ff[i]   <= ws_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         idx_ff <= '0;
      end else begin
         if (cmd.write_slot && act_ff == tct_pkg::ACT_DOWN) begin
            cnt_ff <= cnt_ff + tct_pkg::CNT_W'(1);
         end else if (cmd.remove) begin
            cnt_ff <= cnt_ff - tct_pkg::CNT_W'(1);
         end
         if (cmd.emit) begin
            idx_ff <= emit_last ? '0 : idx_ff + tct_pkg::SLOT_W'(1);
         end
      end
      if (cmd.set_err) begin
         err_ff <= cmd.err_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_stamp_ff <= stamp_ff;
         out_cnt_ff   <= 3'(cnt_ff);
         out_last_ff  <= emit_last;
         out_err_ff   <= err_ff;
         if (cnt_ff == '0) begin
            out_has_ff  <= 1'b0;
            out_slot_ff <= '0;
            out_tip_ff  <= 1'b0;
            out_id_ff   <= '0;
            out_x_ff    <= '0;
            out_y_ff    <= '0;
            out_w_ff    <= '0;
         end else begin
            out_has_ff  <= 1'b1;
            out_slot_ff <= 3'(idx_ff);
            out_tip_ff  <= tips_ff[idx_ff];
            out_id_ff   <= ids_ff[idx_ff];
            out_x_ff    <= xs_ff[idx_ff];
            out_y_ff    <= ys_ff[idx_ff];
            out_w_ff    <= ws_ff[idx_ff];
         end
      end
   end

   always_comb begin
      stat.action    = act_ff;
      stat.found     = found;
      stat.full      = (cnt_ff >= tct_pkg::CNT_W'(N));
      stat.div_done  = dx_done & dy_done;
      stat.out_free  = !out_valid_ff || rsp_ready;
      stat.emit_last = emit_last;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_has_contact  = out_has_ff;
   assign rsp_slot         = out_slot_ff;
   assign rsp_tip          = out_tip_ff;
   assign rsp_contact_id   = out_id_ff;
   assign rsp_pos_x        = out_x_ff;
   assign rsp_pos_y        = out_y_ff;
   assign rsp_width_out    = out_w_ff;
   assign rsp_report_stamp = out_stamp_ff;
   assign rsp_active_count = out_cnt_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_error        = out_err_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= tct_pkg::CNT_W'(N))
      else $error("active contact count exceeds the table size");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_has_ff) |-> (out_slot_ff < out_cnt_ff))
      else $error("reported slot lies beyond the active count");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_has_ff) |-> (out_last_ff && out_cnt_ff == '0))
      else $error("empty report is not a single final result");

endmodule

// ===== hw/rtl/tct_controller.sv =====
// Controller state machine: sequences accept, slot decision, scaling, table update
// and result emission. Depends on tct_pkg.
module tct_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tct_pkg::dp_stat_type  stat,
   output tct_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
            if (req_valid) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.set_err  = 1'b1;
            cmd.err_code = tct_pkg::ERR_OK;
            unique case (stat.action)
               tct_pkg::ACT_DOWN: begin
                  if (stat.full) begin
                     cmd.err_code = tct_pkg::ERR_FULL;
                     state_in     = ST_EMIT;
                  end else begin
                     cmd.start_div = 1'b1;
                     state_in      = ST_DIVIDE;
                  end
               end
               tct_pkg::ACT_MOVE: begin
                  if (stat.found) begin
                     cmd.start_div = 1'b1;
                     state_in      = ST_DIVIDE;
                  end else begin
                     cmd.err_code = tct_pkg::ERR_UNKNOWN;
                     state_in     = ST_EMIT;
                  end
               end
               tct_pkg::ACT_UP: begin
                  if (stat.found) begin
                     cmd.remove = 1'b1;
                  end else begin
                     cmd.err_code = tct_pkg::ERR_UNKNOWN;
                  end
                  state_in = ST_EMIT;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               cmd.write_slot = 1'b1;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_single_update: assert property (@(posedge clock) disable iff (reset)
      !(cmd.write_slot && cmd.remove))
      else $error("slot write and slot removal issued together");

   a_write_after_divide: assert property (@(posedge clock) disable iff (reset)
      cmd.write_slot |-> state_ff == ST_DIVIDE && stat.div_done)
      else $error("slot written without a finished scaling");

endmodule

// ===== hw/rtl/touch_contact_tracker_unit.sv =====
// Top level of the touch contact tracker: controller plus datapath.
// Depends on tct_pkg, tct_controller and tct_datapath.
//
//   Channel   Direction  Handshake              Content
//   req_*     in         req_valid/req_ready    touch event (down, move, up)
//   rsp_*     out        rsp_valid/rsp_ready    one result per active contact, or one empty result if none
//   csr_*     in         csr_we                 swap, full scales, flips
//
// A down or move event is decided, scaled in the bit-serial scalers (thirteen quotient bits)
// and written to its slot before the first result is loaded into the result register; an up
// or rejected event goes from the decision straight to result emission. Further results follow
// while rsp_ready is high. Reset clears the active count, configuration and control state only.
// A low rsp_ready holds the result register; the next request waits for the last result.
module touch_contact_tracker_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_action,
   input  logic [tct_pkg::ID_W-1:0]       req_track_id,
   input  logic [tct_pkg::RAW_W-1:0]      req_raw_x,
   input  logic [tct_pkg::RAW_W-1:0]      req_raw_y,
   input  logic [tct_pkg::WID_W-1:0]      req_contact_width,
   input  logic [tct_pkg::STAMP_W-1:0]    req_scan_stamp,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_has_contact,
   output logic [2:0]                     rsp_slot,
   output logic                           rsp_tip,
   output logic [tct_pkg::ID_W-1:0]       rsp_contact_id,
   output logic [tct_pkg::POS_W-1:0]      rsp_pos_x,
   output logic [tct_pkg::POS_W-1:0]      rsp_pos_y,
   output logic [tct_pkg::WID_W-1:0]      rsp_width_out,
   output logic [tct_pkg::STAMP_W-1:0]    rsp_report_stamp,
   output logic [2:0]                     rsp_active_count,
   output logic                           rsp_last,
   output logic [1:0]                     rsp_error,
   input  logic                           csr_we,
   input  logic [tct_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tct_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tct_pkg::dp_cmd_type  cmd;
   tct_pkg::dp_stat_type stat;

   tct_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tct_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_action        (req_action),
      .req_track_id      (req_track_id),
      .req_raw_x         (req_raw_x),
      .req_raw_y         (req_raw_y),
      .req_contact_width (req_contact_width),
      .req_scan_stamp    (req_scan_stamp),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_has_contact   (rsp_has_contact),
      .rsp_slot          (rsp_slot),
      .rsp_tip           (rsp_tip),
      .rsp_contact_id    (rsp_contact_id),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_width_out     (rsp_width_out),
      .rsp_report_stamp  (rsp_report_stamp),
      .rsp_active_count  (rsp_active_count),
      .rsp_last          (rsp_last),
      .rsp_error         (rsp_error)
   );

endmodule
